/* sv/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants of the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Operation codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PACK = 1'b1;

  // Register indexes (paddr[2]) and reset values
  localparam logic        REG_ATLAS    = 1'b0;
  localparam logic        REG_GUTTER   = 1'b1;
  localparam logic [14:0] ATLAS_RESET  = 15'd4096;
  localparam logic [7:0]  GUTTER_RESET = 8'd1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_BIG   = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } srp_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RK_KEY,
    S_RK_KEYW,
    S_RK_RD,
    S_RK_CMP,
    S_PL_ORD,
    S_PL_CARD,
    S_PL_CALC,
    S_OUT_RD,
    S_OUT_EMIT
  } srp_state_e;

  typedef struct packed {
    logic        operation;
    logic [11:0] card_width;
    logic [11:0] card_height;
  } srp_in_t;

  typedef struct packed {
    logic [5:0]  card_index;
    logic        card_valid;
    logic [13:0] offset_x;
    logic [13:0] offset_y;
    logic        placed;
    logic [1:0]  status;
    logic [14:0] used_height;
    logic        last;
  } srp_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // load word accepted
    logic pack_init;   // pack word accepted with a non-empty set
    logic empty_emit;  // pack word accepted with nothing loaded
    logic rd_key;      // read sizes of the card being ranked
    logic key_lat;     // capture its key
    logic rd_j;        // read sizes of the compared card
    logic cmp_step;    // compare and count
    logic rd_ord;      // read packing order entry
    logic card_lat;    // capture card number, read its sizes
    logic place_step;  // shelf placement of one card
    logic rd_pos;      // read position of result card
    logic emit_step;   // present one result
  } srp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic j_last;
    logic c_last;
    logic k_last;
    logic i_last;
    logic fail;
  } srp_sts_t;

endpackage

/* sv/shelf_rect_packer_top.sv */
// ----------------------------------------------------------------------------
// shelf_rect_packer_top
// Next-fit shelf packer of up to MAX_CARDS rectangles in a square atlas.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken when start is high and busy is low. A load word
//   stores one rectangle size; loads may follow each other back to back.
//   Loads past capacity are dropped and flag overflow.
//   A pack word ranks the set (height desc, width desc, index asc), walks
//   the shelves and then emits one result word per card in load order,
//   each on res_o for one cycle marked by res_valid_o, last on the final.
//   Pack of n cards: the rank pass compares every card with every other
//   through the single read port of the size RAM. A pack of an empty set
//   returns one word the cycle after it is taken.
//   Results cannot be held off; the receiver takes each word as shown.
//   Configuration (atlas size at 0x0, gutter at 0x4) goes over the APB
//   port while the block is idle; pready is always high.
//   Reset clears the loaded set, overflow and shelf state; registers
//   return to atlas 4096, gutter 1.
// ----------------------------------------------------------------------------
module shelf_rect_packer_top #(
  parameter int unsigned MAX_CARDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  srp_pkg::srp_in_t  in_item_i,
  // result channel
  output logic              res_valid_o,
  output srp_pkg::srp_res_t res_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import srp_pkg::*;

  logic [14:0] atlas_q;
  logic [7:0]  gutter_q;
  logic        cfg_wr;
  srp_cmd_t    cmd;
  srp_sts_t    sts;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_q  <= ATLAS_RESET;
      gutter_q <= GUTTER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ATLAS:  atlas_q  <= pwdata[14:0];
        REG_GUTTER: gutter_q <= pwdata[7:0];
        default:    atlas_q  <= atlas_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_GUTTER) ? {24'd0, gutter_q} : {17'd0, atlas_q};

  srp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (in_item_i.operation),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  srp_dp #(.MAX_CARDS(MAX_CARDS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .atlas_i     (atlas_q),
    .gutter_i    (gutter_q),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* sv/srp_ram.sv */
// ----------------------------------------------------------------------------
// srp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/srp_ctrl.sv */
// ----------------------------------------------------------------------------
// srp_ctrl
// Sequencer: load, rank pass, shelf placement walk, result walk.
// ----------------------------------------------------------------------------
module srp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             operation_i,
  input  srp_pkg::srp_sts_t sts_i,
  output srp_pkg::srp_cmd_t cmd_o,
  output logic             busy
);
  import srp_pkg::*;

  srp_state_e state_q, state_d;
  logic       accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && operation_i == OP_PACK && !sts_i.empty) state_d = S_RK_KEY;
      end
      S_RK_KEY:  state_d = S_RK_KEYW;
      S_RK_KEYW: state_d = S_RK_RD;
      S_RK_RD:   state_d = S_RK_CMP;
      S_RK_CMP: begin
        if (!sts_i.j_last)     state_d = S_RK_RD;
        else if (sts_i.c_last) state_d = S_PL_ORD;
        else                   state_d = S_RK_KEY;
      end
      S_PL_ORD:  state_d = S_PL_CARD;
      S_PL_CARD: state_d = S_PL_CALC;
      S_PL_CALC: begin
        state_d = (sts_i.fail || sts_i.k_last) ? S_OUT_RD : S_PL_ORD;
      end
      S_OUT_RD:  state_d = S_OUT_EMIT;
      S_OUT_EMIT: begin
        state_d = sts_i.i_last ? S_IDLE : S_OUT_RD;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load       = accept && (operation_i == OP_LOAD);
        cmd_o.pack_init  = accept && (operation_i == OP_PACK) && !sts_i.empty;
        cmd_o.empty_emit = accept && (operation_i == OP_PACK) && sts_i.empty;
      end
      S_RK_KEY:   cmd_o.rd_key     = 1'b1;
      S_RK_KEYW:  cmd_o.key_lat    = 1'b1;
      S_RK_RD:    cmd_o.rd_j       = 1'b1;
      S_RK_CMP:   cmd_o.cmp_step   = 1'b1;
      S_PL_ORD:   cmd_o.rd_ord     = 1'b1;
      S_PL_CARD:  cmd_o.card_lat   = 1'b1;
      S_PL_CALC:  cmd_o.place_step = 1'b1;
      S_OUT_RD:   cmd_o.rd_pos     = 1'b1;
      S_OUT_EMIT: cmd_o.emit_step  = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

endmodule

/* sv/srp_dp.sv */
// ----------------------------------------------------------------------------
// srp_dp
// Datapath: size store, rank counter, order store, shelf state, positions.
// ----------------------------------------------------------------------------
module srp_dp #(
  parameter int unsigned MAX_CARDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srp_pkg::srp_cmd_t cmd_i,
  input  srp_pkg::srp_in_t  in_item_i,
  input  logic [14:0]       atlas_i,
  input  logic [7:0]        gutter_i,
  output srp_pkg::srp_sts_t sts_o,
  output logic              res_valid_o,
  output srp_pkg::srp_res_t res_o
);
  import srp_pkg::*;

  localparam int unsigned IDX_W = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  // set bookkeeping
  logic [CNT_W-1:0] cnt_q, n_m1;
  logic             ovf_q, full;
  // loop counters
  logic [IDX_W-1:0] c_q, j_q, k_q, i_q, rank_q, rank_n, card_q;
  // rank key of card c
  logic [11:0]      key_w_q, key_h_q;
  logic             lt;
  // shelf state
  logic [14:0]      cx_q, top_q;
  logic [12:0]      tall_q;
  srp_status_e      stat_q;
  logic [MAX_CARDS-1:0] flags_q;
  // memory ports
  logic [IDX_W-1:0] wh_raddr;
  logic [23:0]      wh_rdata;
  logic [IDX_W-1:0] ord_rdata;
  logic [27:0]      pos_rdata;
  logic             ord_we, pos_we;
  // placement arithmetic
  logic [12:0]      pw, ph;
  logic [15:0]      cx_end, top_nl, y_end, used_sum;
  logic             too_big, new_line, exhausted;
  logic [14:0]      top_n, cx_n;
  logic [14:0]      used_sat;
  srp_status_e      res_stat;
  srp_res_t         res_d;
  logic             res_valid_d;

  assign full = (cnt_q >= CNT_W'(MAX_CARDS));
  assign n_m1 = cnt_q - 1'b1;

  // status to controller
  assign sts_o.empty  = (cnt_q == '0);
  assign sts_o.j_last = ({1'b0, j_q} == n_m1);
  assign sts_o.c_last = ({1'b0, c_q} == n_m1);
  assign sts_o.k_last = ({1'b0, k_q} == n_m1);
  assign sts_o.i_last = ({1'b0, i_q} == n_m1);
  assign sts_o.fail   = cmd_i.place_step && (too_big || exhausted);

  // size store read address
  always_comb begin
    priority if (cmd_i.rd_key)  wh_raddr = c_q;
    else if (cmd_i.card_lat)    wh_raddr = ord_rdata;
    else                        wh_raddr = j_q;
  end

  srp_ram #(.WIDTH(24), .DEPTH(MAX_CARDS)) u_wh_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({in_item_i.card_height, in_item_i.card_width}),
    .raddr_i (wh_raddr),
    .rdata_o (wh_rdata)
  );

  // rank compare: does card j go before card c
  assign lt = (wh_rdata[23:12] > key_h_q) ||
              ((wh_rdata[23:12] == key_h_q) && (wh_rdata[11:0] > key_w_q)) ||
              ((wh_rdata[23:12] == key_h_q) && (wh_rdata[11:0] == key_w_q) &&
               (j_q < c_q));
  assign rank_n = rank_q + IDX_W'(lt);
  assign ord_we = cmd_i.cmp_step && sts_o.j_last;

  srp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CARDS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (rank_n),
    .wdata_i (c_q),
    .raddr_i (k_q),
    .rdata_o (ord_rdata)
  );

  // shelf placement of one card
  assign pw        = {1'b0, wh_rdata[11:0]} + {5'd0, gutter_i};
  assign ph        = {1'b0, wh_rdata[23:12]} + {5'd0, gutter_i};
  assign too_big   = ({2'b0, pw} > atlas_i) || ({2'b0, ph} > atlas_i);
  assign cx_end    = {1'b0, cx_q} + {3'd0, pw};
  assign new_line  = (cx_end > {1'b0, atlas_i});
  assign top_nl    = {1'b0, top_q} + {3'd0, tall_q};
  assign top_n     = new_line ? top_nl[14:0] : top_q;
  assign cx_n      = new_line ? '0 : cx_q;
  assign y_end     = {1'b0, top_n} + {3'd0, ph};
  assign exhausted = (y_end > {1'b0, atlas_i});
  assign pos_we    = cmd_i.place_step && !too_big && !exhausted;

  srp_ram #(.WIDTH(28), .DEPTH(MAX_CARDS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (card_q),
    .wdata_i ({top_n[13:0], cx_n[13:0]}),
    .raddr_i (i_q),
    .rdata_o (pos_rdata)
  );

  // result word
  assign used_sum = {1'b0, top_q} + {3'd0, tall_q};
  assign used_sat = used_sum[15] ? 15'h7FFF : used_sum[14:0];
  assign res_stat = (stat_q != STAT_OK) ? stat_q : (ovf_q ? STAT_OVERFLOW : STAT_OK);

  always_comb begin
    res_d       = '0;
    res_valid_d = 1'b0;
    if (cmd_i.empty_emit) begin
      res_valid_d = 1'b1;
      res_d.status = ovf_q ? STAT_OVERFLOW : STAT_OK;
      res_d.last   = 1'b1;
    end else if (cmd_i.emit_step) begin
      res_valid_d       = 1'b1;
      res_d.card_index  = 6'(i_q);
      res_d.card_valid  = 1'b1;
      res_d.placed      = flags_q[i_q];
      res_d.offset_x    = flags_q[i_q] ? pos_rdata[13:0] : '0;
      res_d.offset_y    = flags_q[i_q] ? pos_rdata[27:14] : '0;
      res_d.status      = res_stat;
      res_d.used_height = used_sat;
      res_d.last        = sts_o.i_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      c_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      rank_q      <= '0;
      cx_q        <= '0;
      top_q       <= '0;
      tall_q      <= '0;
      stat_q      <= STAT_OK;
      flags_q     <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= res_valid_d;
      if (cmd_i.load) begin
        if (full) ovf_q <= 1'b1;
        else      cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.empty_emit) ovf_q <= 1'b0;
      if (cmd_i.pack_init) begin
        c_q     <= '0;
        j_q     <= '0;
        k_q     <= '0;
        i_q     <= '0;
        rank_q  <= '0;
        cx_q    <= '0;
        top_q   <= '0;
        tall_q  <= '0;
        stat_q  <= STAT_OK;
        flags_q <= '0;
      end
      if (cmd_i.cmp_step) begin
        if (sts_o.j_last) begin
          j_q    <= '0;
          rank_q <= '0;
          c_q    <= c_q + 1'b1;
        end else begin
          j_q    <= j_q + 1'b1;
          rank_q <= rank_n;
        end
      end
      if (cmd_i.place_step) begin
        k_q <= k_q + 1'b1;
        if (too_big) begin
          stat_q <= STAT_TOO_BIG;
        end else begin
          top_q <= top_n;
          if (exhausted) begin
            stat_q <= STAT_EXHAUSTED;
            if (new_line) begin
              cx_q   <= '0;
              tall_q <= '0;
            end
          end else begin
            flags_q[card_q] <= 1'b1;
            cx_q   <= cx_n + {2'b0, pw};
            if (new_line || ph > tall_q) tall_q <= ph;
          end
        end
      end
      if (cmd_i.emit_step) begin
        i_q <= i_q + 1'b1;
        if (sts_o.i_last) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_lat) begin
      key_w_q <= wh_rdata[11:0];
      key_h_q <= wh_rdata[23:12];
    end
    if (cmd_i.card_lat) card_q <= ord_rdata;
    res_o <= res_d;
  end

  // a result word only follows an emit command
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(cmd_i.emit_step || cmd_i.empty_emit))
    else $error("result without emit command");

  // the set never grows past capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CARDS))
    else $error("loaded count above capacity");

  // the empty-set word is always the last of its run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.card_valid) |-> res_o.last)
    else $error("empty-set word not last");

  // a placed card never lands after a failure
  a_no_place_after_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.place_step && stat_q != STAT_OK) |-> 1'b0)
    else $error("placement after failure");

  // memory read commands never overlap
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.rd_key, cmd_i.rd_j, cmd_i.rd_ord, cmd_i.card_lat, cmd_i.rd_pos}))
    else $error("overlapping read commands");

endmodule
